[hw/rtl/bgre_pkg.sv]
package bgre_pkg;

    localparam int GLYPH_ROWS = 9;
    localparam int GLYPH_COLS = 6;
    localparam int PEN_STEP   = GLYPH_COLS + 1;
    localparam int ROW_W      = $clog2(GLYPH_ROWS);
    localparam int COL_W      = $clog2(GLYPH_COLS + 1);
    localparam int COORD_W    = 16;
    localparam int SCALE_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [GLYPH_COLS-1:0] glyph_row_t;

    typedef struct packed {
        logic                                   known;
        logic [GLYPH_ROWS*GLYPH_COLS-1:0]       rows;
    } glyph_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_PIXEL_SCALE = 3'd2,
        CFG_OBLIQUE     = 3'd3,
        CFG_DRAW_COLOUR = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_ERROR,
        ST_ADVANCE
    } state_t;

    typedef struct packed {
        logic accept;
        logic load_glyph;
        logic emit_run;
        logic emit_unknown;
        logic next_row;
        logic advance_pen;
    } ctrl_cmd_t;

    typedef struct packed {
        logic known;
        logic row_has_run;
        logic last_row;
        logic slot_free;
    } dp_status_t;

    // Row 0 lands in the low bits.
    function automatic logic [GLYPH_ROWS*GLYPH_COLS-1:0] pack9(
        input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
        input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5,
        input logic [7:0] b6, input logic [7:0] b7, input logic [7:0] b8
    );
        return {b8[5:0], b7[5:0], b6[5:0], b5[5:0], b4[5:0],
                b3[5:0], b2[5:0], b1[5:0], b0[5:0]};
    endfunction

    function automatic glyph_t glyph_lookup(input logic [7:0] code);
        glyph_t g;
        g.known = 1'b1;
        case (code)
            8'h41: g.rows = pack9(8'h0C,8'h1E,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h33,8'h33);
            8'h42: g.rows = pack9(8'h3E,8'h33,8'h33,8'h33,8'h3E,8'h33,8'h33,8'h33,8'h3E);
            8'h43: g.rows = pack9(8'h1E,8'h33,8'h33,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1E);
            8'h44: g.rows = pack9(8'h3C,8'h36,8'h33,8'h33,8'h33,8'h33,8'h33,8'h36,8'h3C);
            8'h45: g.rows = pack9(8'h3F,8'h30,8'h30,8'h30,8'h3C,8'h30,8'h30,8'h30,8'h3F);
            8'h46: g.rows = pack9(8'h3F,8'h30,8'h30,8'h30,8'h3C,8'h30,8'h30,8'h30,8'h30);
            8'h47: g.rows = pack9(8'h1E,8'h33,8'h30,8'h30,8'h37,8'h33,8'h33,8'h33,8'h1E);
            8'h48: g.rows = pack9(8'h33,8'h33,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h33,8'h33);
            8'h49: g.rows = pack9(8'h3F,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h3F);
            8'h4A: g.rows = pack9(8'h0F,8'h06,8'h06,8'h06,8'h06,8'h06,8'h36,8'h36,8'h1C);
            8'h4B: g.rows = pack9(8'h33,8'h36,8'h3C,8'h38,8'h30,8'h38,8'h3C,8'h36,8'h33);
            8'h4C: g.rows = pack9(8'h30,8'h30,8'h30,8'h30,8'h30,8'h30,8'h30,8'h30,8'h3F);
            8'h4D: g.rows = pack9(8'h33,8'h3F,8'h3F,8'h33,8'h33,8'h33,8'h33,8'h33,8'h33);
            8'h4E: g.rows = pack9(8'h33,8'h3B,8'h3B,8'h3F,8'h37,8'h37,8'h33,8'h33,8'h33);
            8'h4F: g.rows = pack9(8'h1E,8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h1E);
            8'h50: g.rows = pack9(8'h3E,8'h33,8'h33,8'h33,8'h3E,8'h30,8'h30,8'h30,8'h30);
            8'h51: g.rows = pack9(8'h1E,8'h33,8'h33,8'h33,8'h33,8'h33,8'h37,8'h36,8'h1D);
            8'h52: g.rows = pack9(8'h3E,8'h33,8'h33,8'h33,8'h3E,8'h38,8'h34,8'h36,8'h33);
            8'h53: g.rows = pack9(8'h1E,8'h33,8'h30,8'h38,8'h1E,8'h07,8'h03,8'h33,8'h1E);
            8'h54: g.rows = pack9(8'h3F,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C);
            8'h55: g.rows = pack9(8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h1E);
            8'h56: g.rows = pack9(8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h1E,8'h0C);
            8'h57: g.rows = pack9(8'h33,8'h33,8'h33,8'h33,8'h33,8'h3F,8'h3F,8'h3F,8'h33);
            8'h58: g.rows = pack9(8'h33,8'h33,8'h1E,8'h1E,8'h0C,8'h1E,8'h1E,8'h33,8'h33);
            8'h59: g.rows = pack9(8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C);
            8'h5A: g.rows = pack9(8'h3F,8'h03,8'h06,8'h0C,8'h0C,8'h18,8'h30,8'h30,8'h3F);
            8'h30: g.rows = pack9(8'h1E,8'h33,8'h33,8'h37,8'h3F,8'h3B,8'h33,8'h33,8'h1E);
            8'h31: g.rows = pack9(8'h0C,8'h1C,8'h3C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h3F);
            8'h32: g.rows = pack9(8'h1E,8'h33,8'h03,8'h06,8'h0C,8'h18,8'h30,8'h30,8'h3F);
            8'h33: g.rows = pack9(8'h3F,8'h06,8'h0C,8'h1E,8'h03,8'h03,8'h03,8'h33,8'h1E);
            8'h34: g.rows = pack9(8'h06,8'h0E,8'h1E,8'h36,8'h36,8'h3F,8'h06,8'h06,8'h06);
            8'h35: g.rows = pack9(8'h3F,8'h30,8'h30,8'h3E,8'h03,8'h03,8'h03,8'h33,8'h1E);
            8'h36: g.rows = pack9(8'h0E,8'h18,8'h30,8'h30,8'h3E,8'h33,8'h33,8'h33,8'h1E);
            8'h37: g.rows = pack9(8'h3F,8'h03,8'h06,8'h06,8'h0C,8'h0C,8'h18,8'h18,8'h18);
            8'h38: g.rows = pack9(8'h1E,8'h33,8'h33,8'h1E,8'h1E,8'h33,8'h33,8'h33,8'h1E);
            8'h39: g.rows = pack9(8'h1E,8'h33,8'h33,8'h33,8'h1F,8'h03,8'h03,8'h06,8'h1C);
            8'h20: g.rows = '0;
            8'h2E: g.rows = pack9(8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C);
            8'h2C: g.rows = pack9(8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C,8'h18);
            8'h3A: g.rows = pack9(8'h00,8'h00,8'h0C,8'h0C,8'h00,8'h00,8'h0C,8'h0C,8'h00);
            8'h21: g.rows = pack9(8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h00,8'h0C,8'h0C);
            8'h3F: g.rows = pack9(8'h1E,8'h33,8'h03,8'h06,8'h0C,8'h0C,8'h00,8'h0C,8'h0C);
            8'h2D: g.rows = pack9(8'h00,8'h00,8'h00,8'h00,8'h3F,8'h00,8'h00,8'h00,8'h00);
            8'h2B: g.rows = pack9(8'h00,8'h00,8'h0C,8'h0C,8'h3F,8'h0C,8'h0C,8'h00,8'h00);
            8'h2F: g.rows = pack9(8'h03,8'h03,8'h06,8'h06,8'h0C,8'h18,8'h18,8'h30,8'h30);
            8'h26: g.rows = pack9(8'h1C,8'h36,8'h36,8'h1C,8'h3B,8'h37,8'h36,8'h37,8'h1D);
            8'h27: g.rows = pack9(8'h0C,8'h0C,8'h18,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00);
            8'h28: g.rows = pack9(8'h06,8'h0C,8'h18,8'h18,8'h18,8'h18,8'h18,8'h0C,8'h06);
            8'h29: g.rows = pack9(8'h18,8'h0C,8'h06,8'h06,8'h06,8'h06,8'h06,8'h0C,8'h18);
            8'h3E: g.rows = pack9(8'h18,8'h0C,8'h06,8'h03,8'h06,8'h0C,8'h18,8'h00,8'h00);
            8'h3C: g.rows = pack9(8'h06,8'h0C,8'h18,8'h30,8'h18,8'h0C,8'h06,8'h00,8'h00);
            default:
            begin
                g.known = 1'b0;
                g.rows  = '0;
            end
        endcase
        return g;
    endfunction

endpackage

[hw/rtl/bgre_char_if.sv]
interface bgre_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       first_of_text;

    modport source (output valid, output char_code, output first_of_text, input ready);
    modport sink   (input valid, input char_code, input first_of_text, output ready);
endinterface

[hw/rtl/bgre_run_if.sv]
interface bgre_run_if;
    logic        valid;
    logic        ready;
    logic [15:0] run_top_y;
    logic [15:0] run_start_x;
    logic [15:0] run_end_x;
    logic [3:0]  run_height;
    logic        last_run;
    logic        unknown_char;

    modport source (output valid, output run_top_y, output run_start_x, output run_end_x,
                    output run_height, output last_run, output unknown_char, input ready);
    modport sink   (input valid, input run_top_y, input run_start_x, input run_end_x,
                    input run_height, input last_run, input unknown_char, output ready);
endinterface

[hw/rtl/bgre_ctrl.sv]
module bgre_ctrl
    import bgre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                state_next = status.known ? ST_SCAN : ST_ERROR;
            end
            ST_SCAN:
            begin
                if (!status.row_has_run && status.last_row)
                    state_next = ST_ADVANCE;
            end
            ST_ERROR:
            begin
                if (status.slot_free)
                    state_next = ST_IDLE;
            end
            ST_ADVANCE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_LOOKUP:
            begin
                cmd.load_glyph = 1'b1;
            end
            ST_SCAN:
            begin
                if (status.row_has_run)
                    cmd.emit_run = status.slot_free;
                else if (!status.last_row)
                    cmd.next_row = 1'b1;
            end
            ST_ERROR:
            begin
                cmd.emit_unknown = status.slot_free;
            end
            ST_ADVANCE:
            begin
                cmd.advance_pen = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hw/rtl/bgre_datapath.sv]
module bgre_datapath
    import bgre_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [7:0]            char_code,
    input  logic                  first_of_text,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_W-1:0]    run_top_y,
    output logic [COORD_W-1:0]    run_start_x,
    output logic [COORD_W-1:0]    run_end_x,
    output logic [SCALE_W-1:0]    run_height,
    output logic                  last_run,
    output logic                  unknown_char
);

    // Configuration
    logic [COORD_W-1:0] origin_x_reg;
    logic [COORD_W-1:0] origin_y_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               oblique_reg;

    // Per-character working state
    logic [7:0]         code_reg;
    logic [COORD_W-1:0] pen_reg;
    glyph_row_t         rows_reg [GLYPH_ROWS];
    logic [GLYPH_ROWS-1:0] nz_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;

    // Output slot
    logic               out_valid_reg;
    logic [COORD_W-1:0] top_y_reg;
    logic [COORD_W-1:0] start_x_reg;
    logic [COORD_W-1:0] end_x_reg;
    logic [SCALE_W-1:0] height_reg;
    logic               last_reg;
    logic               unknown_reg;

    glyph_t             glyph;
    logic [SCALE_W-1:0] sc;
    glyph_row_t         row_bits;
    logic [GLYPH_COLS-1:0] cols;
    logic               found;
    logic               end_found;
    logic               more_in_row;
    logic               later_rows;
    logic [COL_W-1:0]   start_col;
    logic [COL_W-1:0]   end_col;
    logic [1:0]         lean_mult;
    logic [5:0]         lean;
    logic [6:0]         start_off;
    logic [6:0]         end_off;
    logic [7:0]         row_off;
    logic [6:0]         pen_step;
    logic               slot_free;

    assign glyph     = glyph_lookup(code_reg);
    assign sc        = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;
    assign row_bits  = rows_reg[row_reg];
    assign slot_free = !out_valid_reg || out_ready;

    // Column c sits at bit GLYPH_COLS-1-c (leftmost column is the MSB)
    always_comb
    begin
        for (int c = 0; c < GLYPH_COLS; c++)
            cols[c] = row_bits[GLYPH_COLS-1-c];
    end

    // Find the next run at or after the column cursor
    always_comb
    begin
        found       = 1'b0;
        start_col   = '0;
        end_found   = 1'b0;
        end_col     = COL_W'(GLYPH_COLS);
        more_in_row = 1'b0;
        later_rows  = 1'b0;
        for (int c = 0; c < GLYPH_COLS; c++)
        begin
            if (!found && cols[c] && (c >= int'(col_reg)))
            begin
                found     = 1'b1;
                start_col = COL_W'(c);
            end
        end
        for (int c = 0; c < GLYPH_COLS; c++)
        begin
            if (found && !end_found && (c > int'(start_col)) && !cols[c])
            begin
                end_found = 1'b1;
                end_col   = COL_W'(c);
            end
        end
        for (int c = 0; c < GLYPH_COLS; c++)
        begin
            if (cols[c] && (c > int'(end_col)))
                more_in_row = 1'b1;
        end
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            if (nz_reg[r] && (r > int'(row_reg)))
                later_rows = 1'b1;
        end
    end

    // In oblique mode, rows 0-2 lean by two scaled pixels, rows 3-5 by one, the rest stay put
    always_comb
    begin
        if (!oblique_reg)
            lean_mult = 2'd0;
        else if (row_reg < ROW_W'(3))
            lean_mult = 2'd2;
        else if (row_reg < ROW_W'(6))
            lean_mult = 2'd1;
        else
            lean_mult = 2'd0;
    end

    assign lean      = 6'(lean_mult) * 6'(sc);
    assign start_off = 7'(start_col) * 7'(sc);
    assign end_off   = 7'(end_col) * 7'(sc);
    assign row_off   = 8'(row_reg) * 8'(sc);
    assign pen_step  = 7'(PEN_STEP) * 7'(sc);

    assign status.known       = glyph.known;
    assign status.row_has_run = found;
    assign status.last_row    = (row_reg == ROW_W'(GLYPH_ROWS - 1));
    assign status.slot_free   = slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_reg    <= SCALE_W'(1);
            oblique_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            // The colour register has no effect on any run; drop its writes
            unique case (cfg_reg_t'(cfg_index))
                CFG_ORIGIN_X:    origin_x_reg <= cfg_wdata[COORD_W-1:0];
                CFG_ORIGIN_Y:    origin_y_reg <= cfg_wdata[COORD_W-1:0];
                CFG_PIXEL_SCALE: scale_reg    <= cfg_wdata[SCALE_W-1:0];
                CFG_OBLIQUE:     oblique_reg  <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pen_reg <= '0;
        else if (cmd.accept && first_of_text)
            pen_reg <= origin_x_reg;
        else if (cmd.advance_pen)
            pen_reg <= pen_reg + COORD_W'(pen_step);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            code_reg <= char_code;
        if (cmd.load_glyph)
        begin
            for (int r = 0; r < GLYPH_ROWS; r++)
            begin
                rows_reg[r] <= glyph.rows[r*GLYPH_COLS +: GLYPH_COLS];
                nz_reg[r]   <= |glyph.rows[r*GLYPH_COLS +: GLYPH_COLS];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.load_glyph)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.next_row)
        begin
            row_reg <= row_reg + ROW_W'(1);
            col_reg <= '0;
        end
        else if (cmd.emit_run)
        begin
            col_reg <= end_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_run || cmd.emit_unknown)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_run)
        begin
            top_y_reg   <= origin_y_reg + COORD_W'(row_off);
            start_x_reg <= pen_reg + COORD_W'(lean) + COORD_W'(start_off);
            end_x_reg   <= pen_reg + COORD_W'(lean) + COORD_W'(end_off);
            height_reg  <= sc;
            last_reg    <= !more_in_row && !later_rows;
            unknown_reg <= 1'b0;
        end
        else if (cmd.emit_unknown)
        begin
            top_y_reg   <= '0;
            start_x_reg <= '0;
            end_x_reg   <= '0;
            height_reg  <= '0;
            last_reg    <= 1'b1;
            unknown_reg <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign run_top_y    = top_y_reg;
    assign run_start_x  = start_x_reg;
    assign run_end_x    = end_x_reg;
    assign run_height   = height_reg;
    assign last_run     = last_reg;
    assign unknown_char = unknown_reg;

endmodule

[hw/rtl/bitmap_glyph_run_emitter_6x9_oblique.sv]
// Oblique 6x9 bitmap glyph run emitter.
// char_in takes one request per character (char_code, first_of_text); run_out
// gives one request per horizontal run of set pixels in the glyph, rows top to
// bottom and runs left to right, with last_run on the final run of a character.
// A character with no glyph gives a single request with unknown_char set; a
// space gives none but still moves the pen. The cfg port writes origin_x,
// origin_y, pixel_scale and oblique_mode at indexes 0..3 and drops writes to
// draw_colour at index 4; write only while no character is in flight.
// Sequence: char_in is taken in the idle state; the glyph ROM is read in the
// next cycle, and a run in row 0 is loaded into the output register from
// the scan state as soon as the output slot is free. The scan emits a row's
// runs left to right and moves to the next row when none are left; after the
// last row the pen advances. The densest glyph has 17 runs.
// One character is in flight at a time.
// Reset clears pen, origins, oblique mode and cursors to 0, scale to 1, and
// empties the output register. When run_out stalls, the run waits in the
// output register and the scan holds, char_in not ready, until the slot frees.
module bitmap_glyph_run_emitter_6x9_oblique
    import bgre_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bgre_char_if.sink             char_in,
    bgre_run_if.source            run_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer: walks lookup, row scan, error report and pen advance
    bgre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_in.valid),
        .in_ready (char_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: config registers, pen, glyph ROM, run finder and output slot
    bgre_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .char_code     (char_in.char_code),
        .first_of_text (char_in.first_of_text),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (run_out.valid),
        .out_ready     (run_out.ready),
        .run_top_y     (run_out.run_top_y),
        .run_start_x   (run_out.run_start_x),
        .run_end_x     (run_out.run_end_x),
        .run_height    (run_out.run_height),
        .last_run      (run_out.last_run),
        .unknown_char  (run_out.unknown_char)
    );

endmodule
